FILE: hw/rtl/wde_pkg.sv
package wde_pkg;

	localparam int DICT_ENTRIES_DEF      = 4096;
	localparam int WORD_BUFFER_BYTES_DEF = 100;

	// Id arithmetic runs at a fixed width that covers the largest table.
	localparam int IDW          = 17;
	localparam int DIGIT_BASE   = 62;
	// floor(x * RECIP_MUL / 2^RECIP_SHIFT) is x / 62 or one below it for x < 2^IDW.
	localparam int RECIP_MUL    = 16912;
	localparam int RECIP_SHIFT  = 20;
	localparam int MAX_DIGITS   = 4;

	localparam int ID_W         = 13;
	localparam int FREQ_W       = 32;
	localparam int TDATA_OUT_W  = 56;

	function automatic logic is_word_byte(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] r;
		if (d < 6'd10) begin
			r = 8'h30 + {2'b00, d};
		end else if (d < 6'd36) begin
			r = 8'h41 + {2'b00, d} - 8'd10;
		end else begin
			r = 8'h61 + {2'b00, d} - 8'd36;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/wde_ram.sv
module wde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/word_dictionary_encoder.sv
// Word dictionary encoder. Text bytes enter one per transaction; runs of ASCII letters
// and digits form words of up to WORD_BUFFER_BYTES-1 bytes. Each finished word is
// searched linearly in the dictionary memories, then its id (1, 2, 3 in order of first
// appearance) leaves as base-62 digit characters, most significant first, followed by
// the byte that ended the word. One item is handled at a time. A non-word byte that ends
// no word goes through the EMIT_RAW state to the output register. A word end costs a
// search with a length read and check per stored entry plus a read and compare per byte
// in entries of equal length, then a read and write per byte to copy a new word into the
// dictionary, the digit conversion with up to MAX_DIGITS digits and the output items,
// one per cycle while m_tready holds. Stream end (tlast) flushes an open word without
// a delimiter.
module word_dictionary_encoder #(
	parameter int DICT_ENTRIES      = wde_pkg::DICT_ENTRIES_DEF,
	parameter int WORD_BUFFER_BYTES = wde_pkg::WORD_BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // stream_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [wde_pkg::TDATA_OUT_W-1:0] m_tdata, // [7:0] out_byte, [20:8] word_id,
	                                                  // [52:21] word_frequency, zero above
	output logic [2:0]  m_tuser,   // [0] is_code, [1] new_word, [2] table_full
	output logic        m_tlast    // last_of_run
);
	import wde_pkg::*;

	localparam int MW   = WORD_BUFFER_BYTES - 1;
	localparam int LW   = $clog2(WORD_BUFFER_BYTES);
	localparam int WAW  = (MW > 1) ? $clog2(MW) : 1;
	localparam int CW   = $clog2(DICT_ENTRIES + 1);
	localparam int EAW  = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
	localparam int SDEP = DICT_ENTRIES * MW;
	localparam int SAW  = (SDEP > 1) ? $clog2(SDEP) : 1;
	localparam int BW   = $clog2(SDEP + 1) + 1;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_LEN_RD   = 4'd1;
	localparam logic [3:0] ST_LEN_CHK  = 4'd2;
	localparam logic [3:0] ST_CMP_RD   = 4'd3;
	localparam logic [3:0] ST_CMP_CHK  = 4'd4;
	localparam logic [3:0] ST_HIT_RD   = 4'd5;
	localparam logic [3:0] ST_HIT_WR   = 4'd6;
	localparam logic [3:0] ST_MISS     = 4'd7;
	localparam logic [3:0] ST_CPY_RD   = 4'd8;
	localparam logic [3:0] ST_CPY_WR   = 4'd9;
	localparam logic [3:0] ST_INS      = 4'd10;
	localparam logic [3:0] ST_DIG      = 4'd11;
	localparam logic [3:0] ST_EMIT_CODE = 4'd12;
	localparam logic [3:0] ST_EMIT_RAW = 4'd13;

	logic [3:0]        state_q;
	logic [LW-1:0]     wlen_q;
	logic [LW-1:0]     fl_q;
	logic [LW-1:0]     j_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     e_q;
	logic [BW-1:0]     ba_q;
	logic [7:0]        raw_q;
	logic              rawp_q;
	logic [IDW-1:0]    x_q;
	logic [2:0]        nd_q;
	logic [1:0]        k_q;
	logic [5:0]        dig_q [MAX_DIGITS];
	logic [ID_W-1:0]   cid_q;
	logic [FREQ_W-1:0] cfreq_q;
	logic              cnew_q;
	logic              cfull_q;

	logic              m_tvalid_q;
	logic [7:0]        ob_q;
	logic              code_q;
	logic [ID_W-1:0]   oid_q;
	logic [FREQ_W-1:0] ofr_q;
	logic              onw_q;
	logic              otf_q;
	logic              olast_q;

	logic              acc;
	logic              wc;
	logic              end_word;
	logic              out_free;
	logic              emit;
	logic              wbuf_we;
	logic [7:0]        wbuf_rdata;
	logic [SAW-1:0]    sb_addr;
	logic              sb_we;
	logic [7:0]        sb_rdata;
	logic              slen_we;
	logic [LW-1:0]     slen_rdata;
	logic              sfreq_we;
	logic [EAW-1:0]    sfreq_waddr;
	logic [FREQ_W-1:0] sfreq_wdata;
	logic [FREQ_W-1:0] sfreq_rdata;
	logic [FREQ_W-1:0] freq_sat;
	logic [CW-1:0]     hit_id;

	logic [31:0]       prod;
	logic [IDW-1:0]    q_est;
	logic [IDW-1:0]    rem;
	logic [IDW-1:0]    q_fix;
	logic [5:0]        digit;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign wc       = is_word_byte(s_tdata);
	assign end_word = (wlen_q != '0) && (!wc || wlen_q == LW'(MW));
	assign out_free = !m_tvalid_q || m_tready;
	assign emit     = out_free && (state_q == ST_EMIT_CODE || state_q == ST_EMIT_RAW);

	assign wbuf_we  = acc && wc && !end_word;
	assign sb_addr  = SAW'(ba_q + BW'(j_q));
	assign sb_we    = (state_q == ST_CPY_WR);
	assign slen_we  = (state_q == ST_INS);
	assign hit_id   = e_q + CW'(1);
	assign freq_sat = (sfreq_rdata == '1) ? sfreq_rdata : sfreq_rdata + FREQ_W'(1);

	always_comb begin
		sfreq_we    = 1'b0;
		sfreq_waddr = e_q[EAW-1:0];
		sfreq_wdata = freq_sat;
		if (state_q == ST_HIT_WR) begin
			sfreq_we = 1'b1;
		end else if (state_q == ST_INS) begin
			sfreq_we    = 1'b1;
			sfreq_waddr = cnt_q[EAW-1:0];
			sfreq_wdata = FREQ_W'(1);
		end
	end

	// Divide by 62 through a reciprocal multiply with one correction step.
	always_comb begin
		prod  = 32'(x_q) * 32'(RECIP_MUL);
		q_est = IDW'(prod >> RECIP_SHIFT);
		rem   = x_q - IDW'(q_est * IDW'(DIGIT_BASE));
		if (rem >= IDW'(DIGIT_BASE)) begin
			q_fix = q_est + IDW'(1);
			digit = 6'(rem - IDW'(DIGIT_BASE));
		end else begin
			q_fix = q_est;
			digit = 6'(rem);
		end
	end

	wde_ram #(.WIDTH(8), .DEPTH(MW)) u_wbuf (
		.clk   (clk),
		.we    (wbuf_we),
		.waddr (wlen_q[WAW-1:0]),
		.wdata (s_tdata),
		.raddr (j_q[WAW-1:0]),
		.rdata (wbuf_rdata)
	);

	wde_ram #(.WIDTH(8), .DEPTH(SDEP)) u_sbytes (
		.clk   (clk),
		.we    (sb_we),
		.waddr (sb_addr),
		.wdata (wbuf_rdata),
		.raddr (sb_addr),
		.rdata (sb_rdata)
	);

	wde_ram #(.WIDTH(LW), .DEPTH(DICT_ENTRIES)) u_slen (
		.clk   (clk),
		.we    (slen_we),
		.waddr (cnt_q[EAW-1:0]),
		.wdata (fl_q),
		.raddr (e_q[EAW-1:0]),
		.rdata (slen_rdata)
	);

	wde_ram #(.WIDTH(FREQ_W), .DEPTH(DICT_ENTRIES)) u_sfreq (
		.clk   (clk),
		.we    (sfreq_we),
		.waddr (sfreq_waddr),
		.wdata (sfreq_wdata),
		.raddr (e_q[EAW-1:0]),
		.rdata (sfreq_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wlen_q     <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready && !emit) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						raw_q <= s_tdata;
						e_q   <= '0;
						ba_q  <= '0;
						if (end_word) begin
							fl_q    <= wlen_q;
							wlen_q  <= '0;
							rawp_q  <= 1'b1;
							state_q <= ST_LEN_RD;
						end else if (wc) begin
							if (s_tlast) begin
								fl_q    <= wlen_q + LW'(1);
								wlen_q  <= '0;
								rawp_q  <= 1'b0;
								state_q <= ST_LEN_RD;
							end else begin
								wlen_q <= wlen_q + LW'(1);
							end
						end else begin
							state_q <= ST_EMIT_RAW;
						end
					end
				end
				ST_LEN_RD: begin
					state_q <= (e_q == cnt_q) ? ST_MISS : ST_LEN_CHK;
				end
				ST_LEN_CHK: begin
					j_q <= '0;
					if (slen_rdata == fl_q) begin
						state_q <= ST_CMP_RD;
					end else begin
						e_q     <= e_q + CW'(1);
						ba_q    <= ba_q + BW'(MW);
						state_q <= ST_LEN_RD;
					end
				end
				ST_CMP_RD: begin
					state_q <= ST_CMP_CHK;
				end
				ST_CMP_CHK: begin
					if (wbuf_rdata == sb_rdata) begin
						if (j_q == fl_q - LW'(1)) begin
							state_q <= ST_HIT_RD;
						end else begin
							j_q     <= j_q + LW'(1);
							state_q <= ST_CMP_RD;
						end
					end else begin
						e_q     <= e_q + CW'(1);
						ba_q    <= ba_q + BW'(MW);
						state_q <= ST_LEN_RD;
					end
				end
				ST_HIT_RD: begin
					state_q <= ST_HIT_WR;
				end
				ST_HIT_WR: begin
					x_q     <= IDW'(hit_id);
					cid_q   <= ID_W'(hit_id);
					cfreq_q <= freq_sat;
					cnew_q  <= 1'b0;
					cfull_q <= 1'b0;
					nd_q    <= '0;
					state_q <= ST_DIG;
				end
				ST_MISS: begin
					j_q <= '0;
					if (cnt_q == CW'(DICT_ENTRIES)) begin
						dig_q[0] <= '0;
						k_q      <= '0;
						cid_q    <= '0;
						cfreq_q  <= '0;
						cnew_q   <= 1'b0;
						cfull_q  <= 1'b1;
						state_q  <= ST_EMIT_CODE;
					end else begin
						state_q <= ST_CPY_RD;
					end
				end
				ST_CPY_RD: begin
					state_q <= ST_CPY_WR;
				end
				ST_CPY_WR: begin
					if (j_q == fl_q - LW'(1)) begin
						state_q <= ST_INS;
					end else begin
						j_q     <= j_q + LW'(1);
						state_q <= ST_CPY_RD;
					end
				end
				ST_INS: begin
					cnt_q   <= cnt_q + CW'(1);
					x_q     <= IDW'(cnt_q) + IDW'(1);
					cid_q   <= ID_W'(cnt_q + CW'(1));
					cfreq_q <= FREQ_W'(1);
					cnew_q  <= 1'b1;
					cfull_q <= 1'b0;
					nd_q    <= '0;
					state_q <= ST_DIG;
				end
				ST_DIG: begin
					dig_q[nd_q[1:0]] <= digit;
					x_q              <= q_fix;
					nd_q             <= nd_q + 3'd1;
					if (q_fix == '0 || nd_q == 3'(MAX_DIGITS - 1)) begin
						k_q     <= nd_q[1:0];
						state_q <= ST_EMIT_CODE;
					end
				end
				ST_EMIT_CODE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						ob_q       <= digit_char(dig_q[k_q]);
						code_q     <= 1'b1;
						oid_q      <= cid_q;
						ofr_q      <= cfreq_q;
						onw_q      <= cnew_q;
						otf_q      <= cfull_q;
						olast_q    <= (k_q == '0) && !rawp_q;
						if (k_q == '0) begin
							state_q <= rawp_q ? ST_EMIT_RAW : ST_IDLE;
						end else begin
							k_q <= k_q - 2'd1;
						end
					end
				end
				ST_EMIT_RAW: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						ob_q       <= raw_q;
						code_q     <= 1'b0;
						oid_q      <= '0;
						ofr_q      <= '0;
						onw_q      <= 1'b0;
						otf_q      <= 1'b0;
						olast_q    <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, ofr_q, oid_q, ob_q};
	assign m_tuser  = {otf_q, onw_q, code_q};
	assign m_tlast  = olast_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DICT_ENTRIES)) else $error("entry count beyond table size");

	a_wlen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wlen_q <= LW'(MW)) else $error("open word longer than buffer");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEN_CHK || state_q == ST_CMP_RD || state_q == ST_CMP_CHK ||
		 state_q == ST_HIT_RD) |-> (e_q < cnt_q)) else $error("search past last entry");

	a_full_item: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tuser[0] && !m_tuser[1] && m_tdata[20:8] == '0))
		else $error("table full item carries word fields");

endmodule
